/* rtl/core/skf_pkg.sv */
package skf_pkg;

  // number formats
  localparam int FRACTION_BITS = 16;
  localparam int DATA_W        = 32;
  localparam int GAIN_BITS     = 16;
  localparam int GAIN_W        = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);
  localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET     = DATA_W'(1) << FRACTION_BITS;
  localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RESET = DATA_W'(2) << FRACTION_BITS;

  // request kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // shared unit widths
  localparam int DEN_W     = DATA_W + 1;
  localparam int REM_W     = DATA_W + 2;
  localparam int MUL_A_W   = DATA_W + 2;
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_COV,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    UOP_NONE,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_MUL
  } uop_t;

  typedef struct packed {
    uop_t                       op;
    logic                       first;
    logic [DATA_W-1:0]          div_num;
    logic [DEN_W-1:0]           div_den;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
  } unit_ctrl_t;

endpackage

/* rtl/core/skf_in_if.sv */
interface skf_in_if;
  import skf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [DATA_W-1:0] measurement;

  modport source (output valid, kind, measurement, input ready);
  modport sink (input valid, kind, measurement, output ready);
endinterface

/* rtl/core/skf_out_if.sv */
interface skf_out_if;
  import skf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate_out;
  logic [DATA_W-1:0]        covariance_out;
  logic [GAIN_W-1:0]        gain_out;

  modport source (output valid, estimate_out, covariance_out, gain_out, input ready);
  modport sink (input valid, estimate_out, covariance_out, gain_out, output ready);
endinterface

/* rtl/core/scalar_kalman_filter.sv */
// channel   | dir | payload                                       | handshake
// samples   | in  | kind, measurement                             | valid/ready
// results   | out | estimate_out, covariance_out, gain_out        | valid/ready
// config    | in  | cfg_wr_en, cfg_index, cfg_wdata               | write enable
//
// a sample request runs ST_PRED, ST_DEN, ST_DIV, ST_MUL_EST, ST_MUL_COV, ST_FIN;
// a clear goes straight to ST_FIN; ST_DIV runs the 17-step restoring gain divider
// ready returns with the result, so a new request can be taken at once
// rst is synchronous; it zeroes estimate and covariance and reloads the noise registers
// a waiting result holds the block in its final step until results.ready
module scalar_kalman_filter
  import skf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  skf_in_if.sink               samples,
  skf_out_if.source            results,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t state, state_next;

  logic [DATA_W-1:0]         process_noise;
  logic [DATA_W-1:0]         measurement_noise;
  logic signed [DATA_W-1:0]  estimate;
  logic [DATA_W-1:0]         covariance;

  logic                      kind_r;
  logic signed [DATA_W-1:0]  meas_r;
  logic [DATA_W-1:0]         pred;
  logic signed [DATA_W:0]    innov;
  logic                      den_zero;
  logic [GAIN_W-1:0]         gain;
  logic [CNT_W-1:0]          cnt;

  logic                      out_valid;
  logic signed [DATA_W-1:0]  est_out_r;
  logic [DATA_W-1:0]         cov_out_r;
  logic [GAIN_W-1:0]         gain_out_r;

  unit_ctrl_t                ctrl;
  logic [GAIN_W-1:0]         quot;
  logic signed [PROD_W-1:0]  prod;

  logic                      in_fire;
  logic                      out_free;
  logic [DATA_W:0]           pred_sum;
  logic [DEN_W-1:0]          den_sum;
  logic [DATA_W-1:0]         prod_q;

  assign in_fire  = samples.valid && samples.ready;
  assign out_free = !out_valid || results.ready;
  assign pred_sum = {1'b0, covariance} + {1'b0, process_noise};
  assign den_sum  = {1'b0, pred} + {1'b0, measurement_noise};
  assign prod_q   = prod[GAIN_BITS+DATA_W-1:GAIN_BITS];

  assign samples.ready          = (state == ST_IDLE);
  assign results.valid          = out_valid;
  assign results.estimate_out   = est_out_r;
  assign results.covariance_out = cov_out_r;
  assign results.gain_out       = gain_out_r;

  skf_unit u_unit (
    .clk  (clk),
    .ctrl (ctrl),
    .quot (quot),
    .prod (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_fire) begin
                    state_next = (samples.kind == KIND_CLEAR) ? ST_FIN : ST_PRED;
                  end
      ST_PRED:    state_next = ST_DEN;
      ST_DEN:     state_next = ST_DIV;
      ST_DIV:     if (cnt == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL_EST;
                  end
      ST_MUL_EST: state_next = ST_MUL_COV;
      ST_MUL_COV: state_next = ST_FIN;
      ST_FIN:     if (out_free) begin
                    state_next = ST_IDLE;
                  end
      default:    state_next = ST_IDLE;
    endcase
  end

  // shared unit control
  always_comb begin
    ctrl.op      = UOP_NONE;
    ctrl.first   = (cnt == '0);
    ctrl.div_num = pred;
    ctrl.div_den = den_sum;
    ctrl.mul_a   = MUL_A_W'(innov);
    ctrl.mul_b   = MUL_B_W'(den_zero ? '0 : quot);
    unique case (state)
      ST_DEN:     ctrl.op = UOP_DIV_INIT;
      ST_DIV:     ctrl.op = UOP_DIV_STEP;
      ST_MUL_EST: ctrl.op = UOP_MUL;
      ST_MUL_COV: begin
        ctrl.op    = UOP_MUL;
        ctrl.mul_a = $signed({2'b00, pred});
        ctrl.mul_b = $signed({1'b0, GAIN_ONE - gain});
      end
      ST_IDLE, ST_PRED, ST_FIN: ctrl.op = UOP_NONE;
      default:    ctrl.op = UOP_NONE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
      estimate          <= '0;
      covariance        <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_PROCESS_NOISE:     process_noise     <= cfg_wdata[DATA_W-1:0];
          REG_MEASUREMENT_NOISE: measurement_noise <= cfg_wdata[DATA_W-1:0];
          default: begin
          end
        endcase
      end
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      // estimate moves by the gain-weighted innovation
      if (state == ST_MUL_COV) begin
        estimate <= estimate + $signed(prod_q);
      end
      // commit the item and present the result
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
        if (kind_r == KIND_CLEAR) begin
          estimate   <= '0;
          covariance <= '0;
        end else begin
          covariance <= prod_q;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= samples.kind;
      meas_r <= samples.measurement;
    end
    // saturating prediction and full-width innovation
    if (state == ST_PRED) begin
      pred  <= pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
      innov <= {meas_r[DATA_W-1], meas_r} - {estimate[DATA_W-1], estimate};
    end
    if (state == ST_DEN) begin
      den_zero <= (den_sum == '0);
      cnt      <= '0;
    end
    if (state == ST_DIV) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (state == ST_MUL_EST) begin
      gain <= den_zero ? '0 : quot;
    end
    if (state == ST_FIN && out_free) begin
      if (kind_r == KIND_CLEAR) begin
        est_out_r  <= '0;
        cov_out_r  <= '0;
        gain_out_r <= '0;
      end else begin
        est_out_r  <= estimate;
        cov_out_r  <= prod_q;
        gain_out_r <= gain;
      end
    end
  end

endmodule

/* rtl/core/skf_unit.sv */
module skf_unit
  import skf_pkg::*;
(
  input  logic                      clk,
  input  unit_ctrl_t                ctrl,
  output logic [GAIN_W-1:0]         quot,
  output logic signed [PROD_W-1:0]  prod
);

  logic [REM_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] den_ext;
  logic             ge;

  // restoring division step: first step compares without shifting
  assign rem_sh  = ctrl.first ? rem : {rem[REM_W-2:0], 1'b0};
  assign den_ext = {1'b0, den};
  assign ge      = (rem_sh >= den_ext);

  // shared divider and multiplier registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      UOP_DIV_INIT: begin
        rem  <= REM_W'(ctrl.div_num);
        den  <= ctrl.div_den;
        quot <= '0;
      end
      UOP_DIV_STEP: begin
        rem  <= ge ? (rem_sh - den_ext) : rem_sh;
        quot <= {quot[GAIN_W-2:0], ge};
      end
      UOP_MUL: begin
        prod <= ctrl.mul_a * ctrl.mul_b;
      end
      UOP_NONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/skf_checker.sv */
module skf_checker
  import skf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] estimate_out,
  input logic [DATA_W-1:0] covariance_out,
  input logic [GAIN_W-1:0] gain_out
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // an accepted request keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain_out <= GAIN_ONE))
    else $error("gain above one");

  // full gain leaves no covariance
  a_full_gain_cov: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gain_out == GAIN_ONE) |-> (covariance_out == '0))
    else $error("covariance left at full gain");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(estimate_out) && $stable(covariance_out) && $stable(gain_out)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .estimate_out   (results.estimate_out),
  .covariance_out (results.covariance_out),
  .gain_out       (results.gain_out)
);

/* tb/tb.sv */
module tb
  import skf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic [DATA_W-1:0]        covariance;
    logic [GAIN_W-1:0]        gain;
  } filter_result_t;

  localparam logic signed [63:0] GAIN_UNITY = 64'(GAIN_ONE);
  localparam logic signed [63:0] COV_MAX    = 64'sh0000_0000_FFFF_FFFF;
  localparam logic signed [63:0] EST_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] EST_MIN    = -64'sh0000_0000_8000_0000;
  localparam logic signed [DATA_W-1:0] MEAS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MEAS_MIN = 32'sh8000_0000;
  localparam logic [DATA_W-1:0] NOISE_MAX = 32'hFFFF_FFFF;
  localparam int SETTLE_CYCLES = 30;

  logic clk;
  logic rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  skf_in_if  samples_if ();
  skf_out_if results_if ();

  scalar_kalman_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // filter state mirrored by the testbench
  logic signed [DATA_W-1:0] est_model = '0;
  logic [DATA_W-1:0]        cov_model = '0;
  logic [DATA_W-1:0]        q_noise   = PROCESS_NOISE_RESET;
  logic [DATA_W-1:0]        r_noise   = MEASUREMENT_NOISE_RESET;

  filter_result_t expected_updates[$];
  int unsigned    mismatches = 0;
  bit             steady     = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // one filter step on the mirrored state
  function automatic filter_result_t predict_update(input logic kind,
                                                    input logic signed [DATA_W-1:0] meas);
    logic signed [63:0] pred;
    logic signed [63:0] den;
    logic signed [63:0] gain;
    logic signed [63:0] innov;
    logic signed [63:0] prod;
    logic signed [63:0] next;
    filter_result_t     res;
    gain = '0;
    if (kind == KIND_CLEAR) begin
      est_model = '0;
      cov_model = '0;
    end else begin
      pred = 64'(cov_model) + 64'(q_noise);
      if (pred > COV_MAX) begin
        pred = COV_MAX;
      end
      den = pred + 64'(r_noise);
      if (den != 0) begin
        gain = (pred <<< 16) / den;
      end
      // floor of innovation times gain
      innov = 64'(meas) - 64'(est_model);
      prod  = innov * gain;
      next  = 64'(est_model) + (prod >>> 16);
      if (next > EST_MAX) begin
        next = EST_MAX;
      end
      if (next < EST_MIN) begin
        next = EST_MIN;
      end
      est_model = next[DATA_W-1:0];
      cov_model = 32'((pred * (GAIN_UNITY - gain)) >>> 16);
    end
    res.estimate   = est_model;
    res.covariance = cov_model;
    res.gain       = gain[GAIN_W-1:0];
    return res;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_noise();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return '0;
    end else if (roll < 20) begin
      return NOISE_MAX;
    end else if (roll < 60) begin
      return $urandom_range(0, 32'h0010_0000);
    end
    return $urandom;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_measurement();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return $urandom;
    end else if (roll < 75) begin
      // close to the current estimate
      return est_model + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    end else if (roll < 85) begin
      case ($urandom_range(0, 3))
        0:       return MEAS_MAX;
        1:       return MEAS_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
  endfunction

  // send one request and record its expected result
  task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] meas);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid       <= 1'b1;
    samples_if.kind        <= kind;
    samples_if.measurement <= meas;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    expected_updates.push_back(predict_update(kind, meas));
  endtask

  // stop requests and wait for every result
  task automatic drain_results();
    samples_if.valid <= 1'b0;
    do @(posedge clk); while (expected_updates.size() != 0);
  endtask

  // both noise registers, written while the filter is idle
  task automatic write_noise(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PROCESS_NOISE;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_index <= REG_MEASUREMENT_NOISE;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    q_noise = q;
    r_noise = r;
  endtask

  // result acceptance with random stalls
  initial begin : result_stall
    int unsigned hold;
    results_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      results_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      hold = pick_gap();
      if (hold != 0) begin
        results_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    filter_result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_updates.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: est %h cov %h gain %h", results_if.estimate_out,
                   results_if.covariance_out, results_if.gain_out);
        end
        mismatches++;
      end else begin
        want = expected_updates.pop_front();
        if (results_if.estimate_out !== want.estimate ||
            results_if.covariance_out !== want.covariance ||
            results_if.gain_out !== want.gain) begin
          if (mismatches < 10) begin
            $display("mismatch: est exp %h got %h, cov exp %h got %h, gain exp %h got %h",
                     want.estimate, results_if.estimate_out, want.covariance,
                     results_if.covariance_out, want.gain, results_if.gain_out);
          end
          mismatches++;
        end
      end
    end
  end

  // samples with the noise values from reset
  task automatic test_reset_noise();
    send_request(KIND_SAMPLE, MEAS_MAX);
    send_request(KIND_SAMPLE, MEAS_MIN);
    send_request(KIND_SAMPLE, '0);
    send_request(KIND_SAMPLE, 32'sh0001_0000);
  endtask

  // clear zeroes every field whatever the sample
  task automatic test_clear();
    send_request(KIND_CLEAR, $urandom);
    send_request(KIND_CLEAR, $urandom);
    send_request(KIND_SAMPLE, -32'sh0005_0000);
  endtask

  // zero denominator gives zero gain
  task automatic test_zero_denominator();
    write_noise('0, '0);
    send_request(KIND_CLEAR, MEAS_MIN);
    send_request(KIND_SAMPLE, MEAS_MAX);
    send_request(KIND_SAMPLE, MEAS_MIN);
  endtask

  // full gain swings the estimate across the whole range
  task automatic test_unity_gain();
    write_noise(NOISE_MAX, '0);
    send_request(KIND_CLEAR, '0);
    send_request(KIND_SAMPLE, MEAS_MAX);
    send_request(KIND_SAMPLE, MEAS_MIN);
    send_request(KIND_SAMPLE, MEAS_MAX);
  endtask

  // saturated prediction and the widest denominator
  task automatic test_saturation();
    write_noise(NOISE_MAX, NOISE_MAX);
    send_request(KIND_SAMPLE, MEAS_MIN);
    send_request(KIND_SAMPLE, MEAS_MAX);
    send_request(KIND_SAMPLE, 32'sd12345);
    write_noise(32'h8000_0000, 32'h0000_0001);
    send_request(KIND_SAMPLE, MEAS_MIN);
    send_request(KIND_SAMPLE, '1);
  endtask

  // random requests over several noise settings
  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      write_noise(pick_noise(), pick_noise());
      steady = (phase % 4 == 3);
      for (int n = 0; n < 128; n++) begin
        if ($urandom_range(0, 99) < 4) begin
          send_request(KIND_CLEAR, $urandom);
        end else begin
          send_request(KIND_SAMPLE, pick_measurement());
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst                    <= 1'b1;
    samples_if.valid       <= 1'b0;
    samples_if.kind        <= KIND_SAMPLE;
    samples_if.measurement <= '0;
    cfg_wr_en              <= 1'b0;
    cfg_index              <= REG_PROCESS_NOISE;
    cfg_wdata              <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_noise();
    test_clear();
    test_zero_denominator();
    test_unity_gain();
    test_saturation();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/skf_pkg.sv
rtl/core/skf_in_if.sv
rtl/core/skf_out_if.sv
rtl/core/skf_unit.sv
rtl/core/scalar_kalman_filter.sv
rtl/core/skf_checker.sv
tb/tb.sv
